// File: hw/rtl/u8gs_pkg.sv
// Package for the UTF-8 glyph selector: shared constants, the job record
// passed from the decoder front end to the result back end, and the atlas map.
// No dependencies.
package u8gs_pkg;

  localparam int CP_W     = 21;
  localparam int BYTE_W   = 8;
  localparam int SEL_W    = 2;
  localparam int IDX_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [CP_W-1:0] REPLACEMENT = CP_W'(32'hFFFD);
  localparam logic [CP_W-1:0] QMARK       = CP_W'(32'd63);
  localparam logic [CP_W-1:0] LATIN_FIRST = CP_W'(32'd32);
  localparam logic [CP_W-1:0] LATIN_LAST  = CP_W'(32'd255);
  localparam logic [CP_W-1:0] KANA_FIRST  = CP_W'(32'h3040);
  localparam logic [CP_W-1:0] KANA_END    = CP_W'(32'h3100);
  localparam logic [CP_W-1:0] ICON_FIRST  = CP_W'(32'hE000);
  localparam logic [CP_W-1:0] ICON_END    = CP_W'(32'hE200);

  localparam logic [SEL_W-1:0] ATLAS_LATIN = 2'd0;
  localparam logic [SEL_W-1:0] ATLAS_KANA  = 2'd1;
  localparam logic [SEL_W-1:0] ATLAS_ICON  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KANA_OK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ICON_OK = 2'd1;

  // Work for one accepted byte: rep_count replacement results, then an
  // optional final result.
  typedef struct packed {
    logic [1:0]      rep_count;
    logic            has_final;
    logic [CP_W-1:0] final_cp;
    logic            final_bad;
  } job_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
  } glyph_t;

  function automatic glyph_t map_glyph(input logic [CP_W-1:0] cp,
                                       input logic kana_ok,
                                       input logic icon_ok);
    glyph_t g;
    logic [CP_W-1:0] diff;
    diff = '0;
    if (cp >= ICON_FIRST && cp < ICON_END && icon_ok) begin
      g.sel = ATLAS_ICON;
      diff  = cp - ICON_FIRST;
    end else if (cp >= KANA_FIRST && cp < KANA_END && kana_ok) begin
      g.sel = ATLAS_KANA;
      diff  = cp - KANA_FIRST;
    end else begin
      g.sel = ATLAS_LATIN;
      if (cp >= LATIN_FIRST && cp <= LATIN_LAST) begin
        diff = cp - LATIN_FIRST;
      end else begin
        diff = QMARK - LATIN_FIRST;
      end
    end
    g.idx = diff[IDX_W-1:0];
    return g;
  endfunction

endpackage

// File: hw/rtl/u8gs_if.sv
// Channel interfaces of the UTF-8 glyph selector: byte input, glyph output,
// and configuration write. Depends on u8gs_pkg.
interface u8gs_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8gs_pkg::BYTE_W-1:0]  text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8gs_glyph_if;
  logic                         valid;
  logic                         ready;
  logic [u8gs_pkg::CP_W-1:0]    code_point;
  logic [u8gs_pkg::SEL_W-1:0]   atlas_sel;
  logic [u8gs_pkg::IDX_W-1:0]   glyph_index;
  logic                         malformed;
  logic                         last_of_run;
  modport source (output valid, output code_point, output atlas_sel,
                  output glyph_index, output malformed, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input atlas_sel,
                  input glyph_index, input malformed, input last_of_run,
                  output ready);
endinterface

interface u8gs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [u8gs_pkg::CFG_IDX_W-1:0]  index;
  logic                            data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/u8gs_front.sv
// Decoder front end: holds the UTF-8 sequence state and turns each accepted
// byte that causes a result into one job record. Depends on u8gs_pkg and u8gs_if.
module u8gs_front (
  input  logic                clk,
  input  logic                rst,
  u8gs_byte_if.sink           text_in,
  input  logic                q_full,
  output logic                push,
  output u8gs_pkg::job_t      push_job
);
  import u8gs_pkg::*;

  logic [1:0]      bytes_remaining, bytes_remaining_next;
  logic [1:0]      bytes_held, bytes_held_next;
  logic [CP_W-1:0] partial_code, partial_code_next;
  logic            accept;
  logic [BYTE_W-1:0] b;
  job_t            job;

  assign text_in.ready = !q_full;
  assign accept        = text_in.valid && !q_full;
  assign b             = text_in.text_byte;

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    bytes_held_next      = bytes_held;
    partial_code_next    = partial_code;
    job                  = '0;
    if (bytes_remaining != 2'd0 && b[7:6] == 2'b10) begin
      partial_code_next    = {partial_code[CP_W-7:0], b[5:0]};
      bytes_remaining_next = bytes_remaining - 2'd1;
      bytes_held_next      = bytes_held + 2'd1;
      if (bytes_remaining == 2'd1) begin
        job.has_final        = 1'b1;
        job.final_cp         = {partial_code[CP_W-7:0], b[5:0]};
        bytes_held_next      = 2'd0;
        partial_code_next    = '0;
      end
    end else begin
      // A broken sequence flushes one replacement for the lead and one for
      // each continuation byte already held, then the byte is decoded fresh.
      if (bytes_remaining != 2'd0) begin
        job.rep_count        = bytes_held + 2'd1;
        bytes_remaining_next = 2'd0;
        bytes_held_next      = 2'd0;
        partial_code_next    = '0;
      end
      if (b == 8'h00) begin
        // End of string gives no result of its own.
      end else if (b[7] == 1'b0) begin
        job.has_final = 1'b1;
        job.final_cp  = CP_W'(b);
      end else if (b[7:5] == 3'b110) begin
        partial_code_next    = CP_W'(b[4:0]);
        bytes_remaining_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial_code_next    = CP_W'(b[3:0]);
        bytes_remaining_next = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial_code_next    = CP_W'(b[2:0]);
        bytes_remaining_next = 2'd3;
      end else begin
        job.has_final = 1'b1;
        job.final_cp  = REPLACEMENT;
        job.final_bad = 1'b1;
      end
    end
  end

  assign push     = accept && (job.rep_count != 2'd0 || job.has_final);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      bytes_held      <= 2'd0;
      partial_code    <= '0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      bytes_held      <= bytes_held_next;
      partial_code    <= partial_code_next;
    end
  end

endmodule

// File: hw/rtl/u8gs_queue.sv
// Short job queue between decoder front end and result back end.
// Depends on u8gs_pkg.
module u8gs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8gs_pkg::job_t  push_job,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output u8gs_pkg::job_t  head
);
  import u8gs_pkg::*;

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/u8gs_back.sv
// Result back end: walks the head job one result per cycle while glyph_out is
// ready, maps each code point to an atlas and glyph index, and holds it in the
// output register. Depends on u8gs_pkg and u8gs_if.
module u8gs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            kana_atlas_ok,
  input  logic            icon_atlas_ok,
  input  logic            q_empty,
  input  u8gs_pkg::job_t  head,
  output logic            pop,
  u8gs_glyph_if.source    glyph_out
);
  import u8gs_pkg::*;

  logic [1:0]      res_cnt;
  logic            out_valid;
  logic            load;
  logic [2:0]      total;
  logic            is_last;
  logic            is_rep;
  logic [CP_W-1:0] cur_cp;
  logic            cur_bad;
  glyph_t          cur_glyph;

  assign total     = {1'b0, head.rep_count} + {2'b00, head.has_final};
  assign is_last   = ({1'b0, res_cnt} + 3'd1) == total;
  assign is_rep    = res_cnt < head.rep_count;
  assign cur_cp    = is_rep ? REPLACEMENT : head.final_cp;
  assign cur_bad   = is_rep ? 1'b1 : head.final_bad;
  assign cur_glyph = map_glyph(cur_cp, kana_atlas_ok, icon_atlas_ok);

  assign load = !q_empty && (!out_valid || glyph_out.ready);
  assign pop  = load && is_last;

  assign glyph_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res_cnt   <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        res_cnt   <= is_last ? 2'd0 : res_cnt + 2'd1;
      end else if (glyph_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph_out.code_point  <= cur_cp;
      glyph_out.atlas_sel   <= cur_glyph.sel;
      glyph_out.glyph_index <= cur_glyph.idx;
      glyph_out.malformed   <= cur_bad;
      glyph_out.last_of_run <= is_last;
    end
  end

endmodule

// File: hw/rtl/utf8_decode_glyph_select.sv
// Top level of the UTF-8 glyph selector: configuration registers, decoder
// front end, job queue and result back end. Depends on u8gs_pkg, u8gs_if,
// u8gs_front, u8gs_queue and u8gs_back.
//
// The block takes a text string one byte per transaction on text_in and
// decodes lenient UTF-8 (1- to 4-byte leads, no overlong or surrogate
// checks). Each decoded code point leaves on glyph_out with its atlas (latin,
// kana or icon) and glyph index; bad leads, stray continuation bytes and
// broken sequences give U+FFFD marked malformed, one for the lead and one for
// each continuation byte held, after which the breaking byte is decoded
// afresh. A zero byte ends the string and flushes any open sequence. Bytes
// are accepted one per cycle as long as the four-entry job queue has room;
// the back end delivers one result transaction per cycle while glyph_out is
// ready, so the results of one byte (at most four) leave one after another,
// and a byte that causes none costs the back end nothing. A result passes
// through the job queue and the output register to glyph_out. Configuration writes
// are accepted every cycle and must be made while the block is idle; an
// unknown register index is ignored. Both atlas enables reset to 1.
module utf8_decode_glyph_select (
  input  logic          clk,
  input  logic          rst,
  u8gs_byte_if.sink     text_in,
  u8gs_glyph_if.source  glyph_out,
  u8gs_cfg_if.sink      cfg
);
  import u8gs_pkg::*;

  logic kana_atlas_ok;
  logic icon_atlas_ok;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  // The register file never stalls a configuration transaction.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kana_atlas_ok <= 1'b1;
      icon_atlas_ok <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_KANA_OK: kana_atlas_ok <= cfg.data;
        CFG_ICON_OK: icon_atlas_ok <= cfg.data;
        default:     ;
      endcase
    end
  end

  // The front end classifies every byte and only queues bytes that cause
  // at least one result.
  u8gs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  u8gs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // The back end expands one job into its results and owns the output
  // register, so the front end keeps taking bytes while a result waits.
  u8gs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .kana_atlas_ok (kana_atlas_ok),
    .icon_atlas_ok (icon_atlas_ok),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .glyph_out     (glyph_out)
  );

endmodule

// File: hw/rtl/u8gs_checker.sv
// Port-level checker for the UTF-8 glyph selector and its bind statement.
// Depends on u8gs_pkg and utf8_decode_glyph_select.
module u8gs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [u8gs_pkg::CP_W-1:0]     code_point,
  input logic [u8gs_pkg::SEL_W-1:0]    atlas_sel,
  input logic [u8gs_pkg::IDX_W-1:0]    glyph_index,
  input logic                          malformed
);
  import u8gs_pkg::*;

  // A replacement result is always U+FFFD drawn as the latin question mark.
  a_malformed_is_qmark: assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |->
      code_point == REPLACEMENT && atlas_sel == ATLAS_LATIN &&
      glyph_index == IDX_W'(QMARK - LATIN_FIRST))
    else $error("malformed result is not a latin replacement");

  // A kana result lies in the kana block and indexes from its first code.
  a_kana_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && atlas_sel == ATLAS_KANA |->
      code_point >= KANA_FIRST && code_point < KANA_END &&
      glyph_index == IDX_W'(code_point - KANA_FIRST))
    else $error("kana glyph index does not match code point");

  // Latin glyph indexes stay within the 224-entry latin atlas.
  a_latin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && atlas_sel == ATLAS_LATIN |->
      glyph_index < IDX_W'(LATIN_LAST - LATIN_FIRST + 1))
    else $error("latin glyph index out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point))
    else $error("stalled result changed");

endmodule

bind utf8_decode_glyph_select u8gs_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (glyph_out.valid),
  .out_ready   (glyph_out.ready),
  .code_point  (glyph_out.code_point),
  .atlas_sel   (glyph_out.atlas_sel),
  .glyph_index (glyph_out.glyph_index),
  .malformed   (glyph_out.malformed)
);

// File: verif/tb_top.sv
// Self-checking testbench for the UTF-8 glyph selector: directed and random text
// streams with atlas enable changes, checked against an in-bench decoder model.
// Depends on u8gs_pkg, the u8gs channel interfaces and utf8_decode_glyph_select.
module tb_top;
  import u8gs_pkg::*;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // Receiver back-pressure modes.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // One expected glyph transaction.
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
    logic             bad;
    logic             last;
  } glyph_rec_t;

  logic clk;
  logic rst;

  u8gs_byte_if  text_in();
  u8gs_glyph_if glyph_out();
  u8gs_cfg_if   cfg();

  utf8_decode_glyph_select i_dut (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .glyph_out (glyph_out),
    .cfg       (cfg)
  );

  // Glyphs predicted for accepted bytes that the block has not delivered yet.
  glyph_rec_t pending_glyphs[$];
  int unsigned errors;

  // Shadow copies of the atlas enables and the decoder state.
  logic            kana_en;
  logic            icon_en;
  logic [1:0]      seq_left;
  logic [1:0]      seq_held;
  logic [CP_W-1:0] seq_code;

  // Sender burst control.
  int  burst_left;
  bit  gaps_off;
  int unsigned bytes_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung handshake; far above the slowest legal run.
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Picks the atlas for a code point. The icon range wins over kana, and each
  // only applies while its atlas is enabled. Everything else is latin, where
  // code points outside 32..255 are drawn as a question mark.
  function automatic glyph_rec_t atlas_lookup(input logic [CP_W-1:0] cp, input logic bad);
    glyph_rec_t g;
    g.cp   = cp;
    g.bad  = bad;
    g.last = 1'b0;
    if (icon_en && cp >= ICON_FIRST && cp < ICON_END) begin
      g.sel = ATLAS_ICON;
      g.idx = IDX_W'(cp - ICON_FIRST);
    end else if (kana_en && cp >= KANA_FIRST && cp < KANA_END) begin
      g.sel = ATLAS_KANA;
      g.idx = IDX_W'(cp - KANA_FIRST);
    end else if (cp >= LATIN_FIRST && cp <= LATIN_LAST) begin
      g.sel = ATLAS_LATIN;
      g.idx = IDX_W'(cp - LATIN_FIRST);
    end else begin
      g.sel = ATLAS_LATIN;
      g.idx = IDX_W'(QMARK - LATIN_FIRST);
    end
    return g;
  endfunction

  // Advances the model by one accepted byte and queues the glyphs it causes.
  // The final glyph of the byte carries last_of_run.
  task automatic decode_text_byte(input logic [7:0] b);
    glyph_rec_t run[$];
    bit         consumed;
    consumed = 1'b0;
    if (seq_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        // Continuation: gather six more bits; the sequence may now be complete.
        consumed = 1'b1;
        seq_code = {seq_code[CP_W-7:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        seq_held = seq_held + 2'd1;
        if (seq_left == 2'd0) begin
          run.push_back(atlas_lookup(seq_code, 1'b0));
          seq_held = 2'd0;
          seq_code = '0;
        end
      end else begin
        // Broken sequence: one replacement for the lead and one per held
        // continuation, then the breaking byte is decoded from idle.
        for (int i = 0; i <= int'(seq_held); i++) begin
          run.push_back(atlas_lookup(REPLACEMENT, 1'b1));
        end
        seq_left = 2'd0;
        seq_held = 2'd0;
        seq_code = '0;
      end
    end
    if (!consumed) begin
      if (b == 8'h00) begin
        // End of string gives nothing of its own.
      end else if (b[7] == 1'b0) begin
        run.push_back(atlas_lookup(CP_W'(b), 1'b0));
      end else if (b[7:5] == 3'b110) begin
        seq_code = CP_W'(b[4:0]);
        seq_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_code = CP_W'(b[3:0]);
        seq_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        seq_code = CP_W'(b[2:0]);
        seq_left = 2'd3;
      end else begin
        // Stray continuation or a lead of F8 and above.
        run.push_back(atlas_lookup(REPLACEMENT, 1'b1));
      end
    end
    if (run.size() != 0) begin
      run[run.size() - 1].last = 1'b1;
    end
    foreach (run[i]) pending_glyphs.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Sends one text byte. Between bursts of random length the sender drops
  // valid for a random gap; a gap of zero leaves the stream unbroken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_off ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        text_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    text_in.valid     <= 1'b1;
    text_in.text_byte <= b;
    do @(posedge clk); while (!text_in.ready);
    decode_text_byte(b);
    bytes_sent++;
  endtask

  // Stops the sender and waits until every predicted glyph has arrived, then
  // lets a byte that causes no glyph clear the pipeline.
  task automatic wait_drain();
    text_in.valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes one register. The caller lowers cfg.valid after its last write so
  // that back-to-back writes keep valid high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CFG_KANA_OK) begin
      kana_en = val;
    end else if (idx == CFG_ICON_OK) begin
      icon_en = val;
    end
  endtask

  // Drains the block, then sets both atlas enables. Optionally pokes the
  // undecoded indexes with the opposite values to show they have no effect.
  task automatic set_atlases(input logic kana, input logic icon, input bit poke_spare);
    wait_drain();
    write_reg(CFG_KANA_OK, kana);
    write_reg(CFG_ICON_OK, icon);
    if (poke_spare) begin
      write_reg(CFG_SPARE_2, ~kana);
      write_reg(CFG_SPARE_3, ~icon);
    end
    cfg.valid <= 1'b0;
  endtask

  // Encodes a code point in len bytes. Overlong forms are legal here, so any
  // code point that fits the payload bits is fine.
  task automatic send_cp(input logic [CP_W-1:0] cp, input int len);
    case (len)
      1: send_byte({1'b0, cp[6:0]});
      2: begin
        send_byte({3'b110, cp[10:6]});
        send_byte({2'b10, cp[5:0]});
      end
      3: begin
        send_byte({4'b1110, cp[15:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
      default: begin
        send_byte({5'b11110, cp[20:18]});
        send_byte({2'b10, cp[17:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Compares one accepted glyph transaction with the oldest prediction.
  task automatic check_glyph();
    glyph_rec_t want;
    if (pending_glyphs.size() == 0) begin
      $display("%0t: unexpected glyph: expected none, actual code point %0h",
               $time, glyph_out.code_point);
      errors++;
    end else begin
      want = pending_glyphs.pop_front();
      check_field("code_point", 32'(want.cp), 32'(glyph_out.code_point));
      check_field("atlas_sel", 32'(want.sel), 32'(glyph_out.atlas_sel));
      check_field("glyph_index", 32'(want.idx), 32'(glyph_out.glyph_index));
      check_field("malformed", 32'(want.bad), 32'(glyph_out.malformed));
      check_field("last_of_run", 32'(want.last), 32'(glyph_out.last_of_run));
    end
  endtask

  // The receiver samples the handshake at each rising edge and then picks the
  // next ready value. Periodically it picks at random among always ready, a coin
  // toss, mostly stalled and a fixed five-of-eight pattern.
  initial begin
    int unsigned rx_cycle;
    rx_mode_t    rx_mode;
    rx_cycle = 0;
    rx_mode  = RX_OPEN;
    glyph_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && glyph_out.valid && glyph_out.ready) begin
        check_glyph();
      end
      if (rx_cycle % 48 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      rx_cycle++;
      case (rx_mode)
        RX_OPEN:   glyph_out.ready <= 1'b1;
        RX_COIN:   glyph_out.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: glyph_out.ready <= ($urandom_range(0, 3) == 0);
        default:   glyph_out.ready <= (rx_cycle % 8 < 5);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single-byte characters at the edges of the ASCII range, including a
  // control code that falls outside the latin atlas.
  task automatic test_ascii_edges();
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'h20);
  endtask

  // Well-formed two-, three- and four-byte sequences with both atlases on:
  // a latin accented letter, a kana, the first icon and an emoji that falls
  // back to the question mark.
  task automatic test_multibyte();
    send_cp(CP_W'(21'h0000E9), 2);
    send_cp(CP_W'(21'h003042), 3);
    send_cp(CP_W'(21'h00E000), 3);
    send_cp(CP_W'(21'h01F600), 4);
  endtask

  // Bad lead, stray continuation, a four-byte sequence broken after three
  // bytes by a printable byte (four glyphs from one byte), a sequence cut by
  // the end of string, and an end of string while idle.
  task automatic test_malformed();
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'hF0);
    send_byte(8'h9F);
    send_byte(8'h98);
    send_byte(8'h41);
    send_byte(8'hC3);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  // One random unit of text. Mostly well-formed characters, with code points
  // bunched around the kana and icon range edges, plus raw noise bytes,
  // deliberately broken sequences and string terminators.
  task automatic send_random_unit();
    int             kind;
    int             len;
    int             held;
    logic [CP_W-1:0] cp;
    logic [7:0]     breaker;
    kind = $urandom_range(0, 99);
    cp   = CP_W'($urandom);
    if (kind < 25) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 40) begin
      send_cp(CP_W'($urandom_range(0, 'h7FF)), 2);
    end else if (kind < 55) begin
      send_cp(CP_W'($urandom_range('h3000, 'h313F)), 3);
    end else if (kind < 70) begin
      send_cp(CP_W'($urandom_range('hDFF0, 'hE20F)), 3);
    end else if (kind < 78) begin
      send_cp(CP_W'($urandom_range(0, 'hFFFF)), 3);
    end else if (kind < 84) begin
      send_cp(cp, 4);
    end else if (kind < 92) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 97) begin
      // Lead plus too few continuations, then a byte that is not one.
      len  = $urandom_range(2, 4);
      held = $urandom_range(0, len - 2);
      case (len)
        2:       send_byte({3'b110, cp[4:0]});
        3:       send_byte({4'b1110, cp[3:0]});
        default: send_byte({5'b11110, cp[2:0]});
      endcase
      repeat (held) send_byte({2'b10, 6'($urandom)});
      breaker = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                            : 8'($urandom_range('hC0, 'hFF));
      send_byte(breaker);
    end else begin
      send_byte(8'h00);
    end
  endtask

  // Random text under every combination of atlas enables. The last phase
  // also writes the undecoded indexes, and one phase runs without sender
  // gaps. Now and then the sender stops until all glyphs are back.
  task automatic test_random_text();
    logic [1:0]  setting[4];
    int unsigned phase_end;
    setting[0] = 2'b00;
    setting[1] = 2'b10;
    setting[2] = 2'b01;
    setting[3] = 2'b11;
    foreach (setting[p]) begin
      set_atlases(setting[p][1], setting[p][0], p == 3);
      gaps_off  = (p == 2);
      phase_end = bytes_sent + 58;
      while (bytes_sent < phase_end) begin
        send_random_unit();
        if ($urandom_range(0, 39) == 0) begin
          wait_drain();
        end
      end
    end
    gaps_off = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    errors     = 0;
    bytes_sent = 0;
    burst_left = 0;
    gaps_off   = 1'b0;
    kana_en    = 1'b1;
    icon_en    = 1'b1;
    seq_left   = 2'd0;
    seq_held   = 2'd0;
    seq_code   = '0;

    rst               <= 1'b1;
    text_in.valid     <= 1'b0;
    text_in.text_byte <= '0;
    cfg.valid         <= 1'b0;
    cfg.index         <= CFG_KANA_OK;
    cfg.data          <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii_edges();
    test_multibyte();
    test_malformed();
    test_random_text();

    // All bytes are in; wait for the last glyphs and a little settling time.
    wait_drain();
    if (pending_glyphs.size() == 0 && errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
